@@ src/hrms_pkg.sv @@
package hrms_pkg;

  localparam int PixelCountBitsDef = 22;
  localparam int MaxFramesDef      = 16;
  localparam int HueWrap           = 180;
  localparam int LowFloor          = 2;
  localparam int HueBits           = 8;

  typedef struct packed {
    logic accum;
    logic clear_frame;
    logic start_frame;
    logic start_set;
  } hrms_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic set_done;
  } hrms_sts_t;

endpackage

@@ src/hrms_if.sv @@
interface hrms_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic       in_mask;
  logic       frame_end;
  logic       set_end;
  modport source (output valid, hue, in_mask, frame_end, set_end, input ready);
  modport sink (input valid, hue, in_mask, frame_end, set_end, output ready);
endinterface

interface hrms_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] avg_hue_min;
  logic [7:0] avg_hue_max;
  modport source (output valid, avg_hue_min, avg_hue_max, input ready);
  modport sink (input valid, avg_hue_min, avg_hue_max, output ready);
endinterface

@@ src/hrms_ctrl.sv @@
module hrms_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_close,
  input  logic             in_set,
  input  logic             out_valid,
  input  logic             out_ready,
  input  hrms_pkg::hrms_sts_t sts,
  output hrms_pkg::hrms_cmd_t cmd,
  output logic             out_load
);
  import hrms_pkg::*;

  typedef enum logic [3:0] {
    S_RUN   = 4'b0001,
    S_FRAME = 4'b0010,
    S_SET   = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   set_r, set_nxt;
  logic   acc;

  assign in_ready = (state_r == S_RUN);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    set_nxt   = set_r;
    cmd       = '0;
    out_load  = 1'b0;
    case (state_r)
      S_RUN: begin
        if (acc) begin
          cmd.accum = 1'b1;
          if (in_close) begin
            cmd.start_frame = 1'b1;
            set_nxt   = in_set;
            state_nxt = S_FRAME;
          end
        end
      end
      S_FRAME: begin
        if (sts.frame_done) begin
          cmd.clear_frame = 1'b1;
          if (set_r) begin
            cmd.start_set = 1'b1;
            state_nxt = S_SET;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end
      S_SET: begin
        if (sts.set_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      set_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      set_r   <= set_nxt;
    end
  end
endmodule

@@ src/hrms_dp.sv @@
module hrms_dp #(
  parameter int PIXEL_COUNT_BITS = hrms_pkg::PixelCountBitsDef,
  parameter int MAX_FRAMES       = hrms_pkg::MaxFramesDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          hue,
  input  logic                in_mask,
  input  hrms_pkg::hrms_cmd_t cmd,
  output hrms_pkg::hrms_sts_t sts,
  output logic [7:0]          avg_min,
  output logic [7:0]          avg_max
);
  import hrms_pkg::*;

  localparam int NB  = PIXEL_COUNT_BITS;
  localparam int SB  = NB + 8;
  localparam int QB  = NB + 16;
  localparam int MB  = 16;
  localparam int VB  = 32;
  localparam int FB  = $clog2(MAX_FRAMES + 1);
  localparam int BB  = FB + 8;
  localparam int DNB = QB + 16;
  localparam int DCB = $clog2(DNB + 1);
  localparam int ACB = $clog2(BB + 1);

  localparam logic [NB-1:0] CountMax = {NB{1'b1}};
  localparam logic [FB-1:0] FrMax    = FB'(MAX_FRAMES);

  typedef enum logic [7:0] {
    P_IDLE = 8'b00000001,
    P_DM   = 8'b00000010,
    P_DQ   = 8'b00000100,
    P_SQ   = 8'b00001000,
    P_BND  = 8'b00010000,
    P_ADD  = 8'b00100000,
    P_AVL  = 8'b01000000,
    P_AVG  = 8'b10000000
  } phase_t;

  logic [NB-1:0]  n_r;
  logic [SB-1:0]  s_r;
  logic [QB-1:0]  q_r;
  logic [BB-1:0]  lsum_r, usum_r;
  logic [FB-1:0]  fc_r;
  phase_t         ph_r;

  logic [DNB-1:0] dnum_r;
  logic [NB:0]    drem_r;
  logic [DCB-1:0] dcnt_r;
  logic [MB-1:0]  mean_r;
  logic [VB-1:0]  msq_r;
  logic [VB-1:0]  var_r;
  logic [15:0]    sqres_r;
  logic [4:0]     scnt_r;
  logic [VB+1:0]  vrem_r;
  logic [8:0]     lo_r, hi_r;
  logic [BB-1:0]  an_r, bn_r;
  logic [BB:0]    ar_r, br_r;
  logic [ACB-1:0] acnt_r;
  logic [7:0]     amin_r, amax_r;

  logic           acc_en;
  logic [SB-1:0]  s_nxt;
  logic [NB:0]    dtrial;
  logic [VB-1:0]  m2;
  logic [VB-1:0]  sqres_w;
  logic [VB+1:0]  vtrial;
  logic [16:0]    dlo, shi;
  logic [8:0]     lo_t, hi_t;
  logic [BB:0]    at, bt;
  logic           a_ge, b_ge;
  logic [VB-1:0]  quot_w;

  assign acc_en  = cmd.accum && in_mask && (n_r != CountMax);
  assign s_nxt   = acc_en ? s_r + SB'(hue) : s_r;
  assign dtrial  = {drem_r[NB-1:0], dnum_r[DNB-1]};
  assign m2      = VB'(mean_r) * VB'(mean_r);
  assign quot_w  = VB'(dnum_r);
  assign sqres_w = VB'(sqres_r);
  assign vtrial  = {vrem_r[VB-1:0], var_r[VB-1 -: 2]} - {sqres_w, 2'b01};
  assign at      = {ar_r[BB-1:0], an_r[BB-1]};
  assign bt      = {br_r[BB-1:0], bn_r[BB-1]};
  assign a_ge    = (at >= (BB+1)'(fc_r));
  assign b_ge    = (bt >= (BB+1)'(fc_r));

  always_comb begin
    dlo  = {1'b0, mean_r} - {1'b0, sqres_r};
    shi  = {1'b0, mean_r} + {1'b0, sqres_r};
    if (dlo[16]) begin
      lo_t = 9'(9'd0 - 9'({1'b0, (17'd0 - dlo)} >> 8));
    end else begin
      lo_t = dlo[16:8];
    end
    hi_t = shi[16:8];
  end

  assign sts.frame_done = (ph_r == P_ADD);
  assign sts.set_done   = (ph_r == P_AVG) && (acnt_r == ACB'(1));
  assign avg_min        = amin_r;
  assign avg_max        = amax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= '0;
      s_r    <= '0;
      q_r    <= '0;
      lsum_r <= '0;
      usum_r <= '0;
      fc_r   <= '0;
      ph_r   <= P_IDLE;
    end else begin
      if (cmd.clear_frame) begin
        n_r <= '0;
        s_r <= '0;
        q_r <= '0;
      end else if (acc_en) begin
        n_r <= n_r + 1'b1;
        s_r <= s_nxt;
        q_r <= q_r + QB'(16'(hue) * 16'(hue));
      end
      case (ph_r)
        P_IDLE: begin
          if (cmd.start_frame) begin
            dnum_r <= DNB'({s_nxt, 8'd0});
            drem_r <= '0;
            dcnt_r <= DCB'(DNB);
            ph_r   <= P_DM;
          end
        end
        P_DM, P_DQ: begin
          if (dcnt_r != '0) begin
            dcnt_r <= dcnt_r - 1'b1;
            if (n_r != '0 && dtrial >= {1'b0, n_r}) begin
              drem_r <= dtrial - {1'b0, n_r};
              dnum_r <= {dnum_r[DNB-2:0], 1'b1};
            end else begin
              drem_r <= dtrial;
              dnum_r <= {dnum_r[DNB-2:0], 1'b0};
            end
          end else if (ph_r == P_DM) begin
            mean_r <= (n_r == '0) ? '0 : quot_w[MB-1:0];
            dnum_r <= DNB'({q_r, 16'd0});
            drem_r <= '0;
            dcnt_r <= DCB'(DNB);
            ph_r   <= P_DQ;
          end else begin
            msq_r   <= (n_r == '0) ? '0 : quot_w;
            ph_r    <= P_SQ;
            scnt_r  <= 5'd17;
            sqres_r <= '0;
            vrem_r  <= '0;
          end
        end
        P_SQ: begin
          if (scnt_r == 5'd17) begin
            var_r  <= (msq_r > m2) ? msq_r - m2 : '0;
            scnt_r <= 5'd16;
          end else if (scnt_r != 5'd0) begin
            scnt_r <= scnt_r - 1'b1;
            var_r  <= {var_r[VB-3:0], 2'b00};
            if (!vtrial[VB+1]) begin
              vrem_r  <= vtrial;
              sqres_r <= {sqres_r[14:0], 1'b1};
            end else begin
              vrem_r  <= {vrem_r[VB-1:0], var_r[VB-1 -: 2]};
              sqres_r <= {sqres_r[14:0], 1'b0};
            end
          end else begin
            lo_r <= lo_t;
            hi_r <= hi_t;
            ph_r <= P_BND;
          end
        end
        P_BND: begin
          if (!lo_r[8] && lo_r <= 9'(LowFloor)) begin
            lo_r <= 9'(LowFloor);
          end else if (lo_r[8]) begin
            lo_r <= lo_r + 9'(HueWrap);
          end
          if (hi_r >= 9'(HueWrap)) begin
            hi_r <= hi_r - 9'(HueWrap);
          end
          ph_r <= P_ADD;
        end
        P_ADD: begin
          if (fc_r < FrMax) begin
            lsum_r <= lsum_r + BB'(lo_r[7:0]);
            usum_r <= usum_r + BB'(hi_r[7:0]);
            fc_r   <= fc_r + 1'b1;
          end
          ph_r <= cmd.start_set ? P_AVL : P_IDLE;
        end
        P_AVL: begin
          an_r   <= lsum_r;
          bn_r   <= usum_r;
          ar_r   <= '0;
          br_r   <= '0;
          acnt_r <= ACB'(BB);
          ph_r   <= P_AVG;
        end
        P_AVG: begin
          acnt_r <= acnt_r - 1'b1;
          if (a_ge) begin
            ar_r <= at - (BB+1)'(fc_r);
            an_r <= {an_r[BB-2:0], 1'b1};
          end else begin
            ar_r <= at;
            an_r <= {an_r[BB-2:0], 1'b0};
          end
          if (b_ge) begin
            br_r <= bt - (BB+1)'(fc_r);
            bn_r <= {bn_r[BB-2:0], 1'b1};
          end else begin
            br_r <= bt;
            bn_r <= {bn_r[BB-2:0], 1'b0};
          end
          if (acnt_r == ACB'(1)) begin
            amin_r <= {an_r[6:0], a_ge};
            amax_r <= {bn_r[6:0], b_ge};
            lsum_r <= '0;
            usum_r <= '0;
            fc_r   <= '0;
            ph_r   <= P_IDLE;
          end
        end
        default: ph_r <= P_IDLE;
      endcase
    end
  end
endmodule

@@ src/hue_range_from_masked_stats.sv @@
// Hue range from masked statistics. Pixels are taken one a cycle while a frame runs.
// The beat that carries frame_end or set_end closes the frame: in_ready then stays low
// through two bit-serial divides, a bit-serial square root, bound folding and summing.
// On set_end in_ready stays low also while the bound averager runs, and longer while
// an earlier result beat still waits.
// One result beat follows each set_end.
module hue_range_from_masked_stats #(
  parameter int PIXEL_COUNT_BITS = hrms_pkg::PixelCountBitsDef,
  parameter int MAX_FRAMES       = hrms_pkg::MaxFramesDef
) (
  input logic       clk,
  input logic       rst_n,
  hrms_in_if.sink   in_ch,
  hrms_out_if.source out_ch
);
  import hrms_pkg::*;

  hrms_cmd_t  cmd;
  hrms_sts_t  sts;
  logic       out_load;
  logic       ov_r;
  logic [7:0] amin, amax;
  logic [7:0] omin_r, omax_r;

  hrms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_close (in_ch.frame_end | in_ch.set_end),
    .in_set   (in_ch.set_end),
    .out_valid(ov_r),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .cmd      (cmd),
    .out_load (out_load)
  );

  hrms_dp #(
    .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS),
    .MAX_FRAMES      (MAX_FRAMES)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .hue    (in_ch.hue),
    .in_mask(in_ch.in_mask),
    .cmd    (cmd),
    .sts    (sts),
    .avg_min(amin),
    .avg_max(amax)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_load) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      omin_r <= amin;
      omax_r <= amax;
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.avg_hue_min = omin_r;
  assign out_ch.avg_hue_max = omax_r;
endmodule

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PixBits   = hrms_pkg::PixelCountBitsDef;
  localparam int FrameCap  = hrms_pkg::MaxFramesDef;
  localparam int CycleCap  = 2000000;

  typedef struct {
    logic [7:0] lo;
    logic [7:0] hi;
  } hue_range_t;

  typedef struct {
    logic [7:0] hue;
    logic       mask;
    logic       fend;
    logic       send;
    logic       typed;
    logic [7:0] lo;
    logic [7:0] hi;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hrms_in_if  in_ch ();
  hrms_out_if out_ch ();

  hue_range_from_masked_stats uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  hue_range_t ranges_due[$];
  int         errors = 0;
  int         cycles = 0;
  int         beats_in = 0;
  int         ranges_seen = 0;
  int         frames_closed = 0;
  int         phase = 0;
  int         hold_left = 0;
  bit         hold_done = 0;

  logic [31:0] pix_n;
  logic [63:0] pix_sum;
  logic [63:0] pix_sq;
  logic [31:0] lo_acc;
  logic [31:0] hi_acc;
  logic [31:0] frames_n;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic close_frame_stats();
    logic [63:0] mean;
    logic [63:0] msq;
    logic [63:0] m2;
    logic [63:0] sd;
    longint      d;
    longint      lo;
    longint      hi;
    mean = '0;
    sd = '0;
    if (pix_n != 0) begin
      mean = (pix_sum << 8) / pix_n;
      msq = (pix_sq << 16) / pix_n;
      m2 = mean * mean;
      sd = (msq > m2) ? int_sqrt(msq - m2) : '0;
    end
    d = longint'(mean) - longint'(sd);
    lo = d / 256;
    hi = longint'((mean + sd) >> 8);
    if (lo >= 0 && lo <= hrms_pkg::LowFloor) lo = hrms_pkg::LowFloor;
    if (lo < 0) lo = lo + hrms_pkg::HueWrap;
    if (hi >= hrms_pkg::HueWrap) hi = hi - hrms_pkg::HueWrap;
    if (frames_n < FrameCap) begin
      lo_acc = lo_acc + 32'(lo);
      hi_acc = hi_acc + 32'(hi);
      frames_n = frames_n + 1;
    end
    pix_n = '0;
    pix_sum = '0;
    pix_sq = '0;
    frames_closed++;
  endtask

  task automatic predict_range(input pixel_row_t p, output bit has, output hue_range_t r);
    has = 1'b0;
    r.lo = '0;
    r.hi = '0;
    if (p.mask && pix_n < (32'd1 << PixBits) - 1) begin
      pix_n = pix_n + 1;
      pix_sum = pix_sum + 64'(p.hue);
      pix_sq = pix_sq + 64'(p.hue) * 64'(p.hue);
    end
    if (p.fend || p.send) close_frame_stats();
    if (p.send) begin
      has = 1'b1;
      if (frames_n != 0) begin
        r.lo = 8'(lo_acc / frames_n);
        r.hi = 8'(hi_acc / frames_n);
      end
      lo_acc = '0;
      hi_acc = '0;
      frames_n = '0;
    end
  endtask

  function automatic int send_idle_pct();
    return (phase == 0) ? 32 : (phase == 1) ? 86 : 0;
  endfunction

  function automatic int recv_idle_pct();
    return (phase == 0) ? 86 : (phase == 1) ? 32 : 0;
  endfunction

  task automatic push_pixel(input pixel_row_t p);
    bit         has;
    hue_range_t r;
    while ($urandom_range(99) < send_idle_pct()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.hue       <= p.hue;
    in_ch.in_mask   <= p.mask;
    in_ch.frame_end <= p.fend;
    in_ch.set_end   <= p.send;
    do @(posedge clk); while (!in_ch.ready);
    beats_in++;
    predict_range(p, has, r);
    if (has) begin
      if (p.typed) begin
        r.lo = p.lo;
        r.hi = p.hi;
      end
      ranges_due.insert(ranges_due.size(), r);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (!hold_done && beats_in >= 700) begin
      hold_done <= 1'b1;
      hold_left <= 3000;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  always @(posedge clk) begin
    hue_range_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      ranges_seen++;
      if (ranges_due.size() == 0) begin
        $error("unexpected result beat: avg_hue_min %0d avg_hue_max %0d",
               out_ch.avg_hue_min, out_ch.avg_hue_max);
        errors++;
      end else begin
        want = ranges_due.pop_front();
        if (out_ch.avg_hue_min !== want.lo) begin
          $error("avg_hue_min: expected %0d, got %0d", want.lo, out_ch.avg_hue_min);
          errors++;
        end
        if (out_ch.avg_hue_max !== want.hi) begin
          $error("avg_hue_max: expected %0d, got %0d", want.hi, out_ch.avg_hue_max);
          errors++;
        end
      end
    end
  end

  pixel_row_t directed [19] = '{
    '{8'd0,   1'b0, 1'b0, 1'b1, 1'b1, 8'd2,   8'd0},
    '{8'd0,   1'b1, 1'b0, 1'b1, 1'b1, 8'd2,   8'd0},
    '{8'd255, 1'b1, 1'b1, 1'b1, 1'b1, 8'd255, 8'd75},
    '{8'd179, 1'b1, 1'b0, 1'b1, 1'b1, 8'd179, 8'd179},
    '{8'd180, 1'b1, 1'b1, 1'b1, 1'b1, 8'd180, 8'd0},
    '{8'd2,   1'b1, 1'b0, 1'b1, 1'b1, 8'd2,   8'd2},
    '{8'd3,   1'b1, 1'b0, 1'b1, 1'b1, 8'd3,   8'd3},
    '{8'd0,   1'b1, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0},
    '{8'd0,   1'b1, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0},
    '{8'd0,   1'b1, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0},
    '{8'd200, 1'b1, 1'b0, 1'b1, 1'b0, 8'd0,   8'd0},
    '{8'd0,   1'b1, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0},
    '{8'd255, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0,   8'd0},
    '{8'd90,  1'b1, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0},
    '{8'd77,  1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0},
    '{8'd100, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0,   8'd0},
    '{8'd170, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0},
    '{8'd175, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0},
    '{8'd60,  1'b0, 1'b1, 1'b1, 1'b0, 8'd0,   8'd0}
  };

  initial begin
    pixel_row_t p;
    int nsets;
    int nframes;
    int npix;
    int wide;
    int base;
    in_ch.valid     <= 1'b0;
    in_ch.hue       <= '0;
    in_ch.in_mask   <= 1'b0;
    in_ch.frame_end <= 1'b0;
    in_ch.set_end   <= 1'b0;
    pix_n = '0;
    pix_sum = '0;
    pix_sq = '0;
    lo_acc = '0;
    hi_acc = '0;
    frames_n = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) push_pixel(directed[i]);

    nsets = 0;
    while (beats_in < 1420) begin
      phase = (beats_in < 520) ? 0 : (beats_in < 1000) ? 1 : 2;
      if (nsets == 20) begin
        // Let the block drain completely before carrying on.
        in_ch.valid <= 1'b0;
        while (ranges_due.size() != 0) @(posedge clk);
      end
      nframes = ($urandom_range(9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 5);
      for (int f = 0; f < nframes; f++) begin
        npix = ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
        wide = $urandom_range(3) == 0;
        base = $urandom_range(179);
        for (int k = 0; k < npix; k++) begin
          p.hue = wide ? 8'($urandom_range(255))
                       : 8'((base + $urandom_range(30)) % 180);
          p.mask = $urandom_range(4) != 0;
          p.fend = 1'b0;
          p.send = 1'b0;
          p.typed = 1'b0;
          p.lo = '0;
          p.hi = '0;
          if (k == npix - 1) begin
            if (f == nframes - 1) begin
              p.send = 1'b1;
              p.fend = 1'($urandom_range(1));
            end else begin
              p.fend = 1'b1;
            end
          end
          push_pixel(p);
        end
      end
      nsets++;
    end
    in_ch.valid <= 1'b0;

    while (ranges_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("run covered %0d pixel beats in %0d frames, %0d range results checked",
             beats_in, frames_closed, ranges_seen);
    if (errors == 0 && ranges_due.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule

@@ hue_range_from_masked_stats.f @@
src/hrms_pkg.sv
src/hrms_if.sv
src/hrms_ctrl.sv
src/hrms_dp.sv
src/hue_range_from_masked_stats.sv
test/testbench.sv
